// ===== hw/rtl/linear_interp_resampler_assert.svh =====
// Assertion macros for the resampler. They compile to nothing in synthesis.
`ifndef LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`define LINEAR_INTERP_RESAMPLER_ASSERT_SVH
`ifndef SYNTHESIS
`define LIR_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("resampler assertion failed");
`define LIR_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("resampler assertion failed");
`else
`define LIR_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define LIR_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hw/rtl/lir_pkg.sv =====
`default_nettype none

package lir_pkg;

  localparam int FRAC_BITS    = 16;
  localparam int MAX_UPSAMPLE = 16;

  localparam int SAMPLE_W = 16;
  localparam int RATIO_W  = 21;
  localparam int PHASE_W  = (RATIO_W > FRAC_BITS) ? RATIO_W : FRAC_BITS;
  localparam int SUM_W    = PHASE_W + 1;
  localparam int CNT_W    = (MAX_UPSAMPLE > 2) ? $clog2(MAX_UPSAMPLE) : 1;
  localparam int DIFF_W   = SAMPLE_W + 1;
  localparam int PROD_W   = FRAC_BITS + 1 + DIFF_W;

  localparam logic [SUM_W-1:0]   ONE_Q       = SUM_W'(1) << FRAC_BITS;
  localparam logic [RATIO_W-1:0] RATIO_RESET = RATIO_W'(65536);
  localparam logic [CNT_W-1:0]   CNT_LAST    = CNT_W'(MAX_UPSAMPLE - 1);

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample_left;
    logic signed [SAMPLE_W-1:0] sample_right;
  } in_word_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] out_left;
    logic signed [SAMPLE_W-1:0] out_right;
    logic                       last_of_run;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic last;
  } issue_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_e;

endpackage

`default_nettype wire

// ===== hw/rtl/lir_lane.sv =====
`default_nettype none

module lir_lane (
  input  logic                                clk_i,
  input  logic                                advance_i,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] prev_i,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] cur_i,
  input  logic        [lir_pkg::FRAC_BITS-1:0] phase_i,
  output logic signed [lir_pkg::SAMPLE_W-1:0] res_o
);
  import lir_pkg::*;

  localparam logic signed [PROD_W-1:0] HALF_Q = PROD_W'(1) << (FRAC_BITS - 1);

  logic signed [DIFF_W-1:0]   diff;
  logic signed [PROD_W-1:0]   prod_d, prod_q;
  logic signed [SAMPLE_W-1:0] base_q;
  logic signed [PROD_W-1:0]   rnd;
  logic signed [PROD_W-1:0]   shf;

  // (1-ph)*a + ph*b is rewritten as a + ph*(b-a), which needs one multiplier.
  assign diff   = DIFF_W'(cur_i) - DIFF_W'(prev_i);
  assign prod_d = PROD_W'($signed({1'b0, phase_i})) * PROD_W'(diff);

  always_ff @(posedge clk_i) begin
    if (advance_i) begin
      prod_q <= prod_d;
      base_q <= prev_i;
    end
  end

  // Arithmetic shift floors, so adding half first rounds ties upward.
  assign rnd   = prod_q + HALF_Q;
  assign shf   = rnd >>> FRAC_BITS;
  assign res_o = base_q + $signed(shf[SAMPLE_W-1:0]);

endmodule

`default_nettype wire

// ===== hw/rtl/lir_ctrl.sv =====
`default_nettype none
`include "linear_interp_resampler_assert.svh"

module lir_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  lir_pkg::in_word_t            in_word_i,
  input  logic                         cfg_we_i,
  input  logic [lir_pkg::RATIO_W-1:0]  cfg_wdata_i,
  input  logic                         advance_i,
  output lir_pkg::issue_t              issue_o,
  output lir_pkg::in_word_t            prev_o,
  output lir_pkg::in_word_t            cur_o,
  output logic [lir_pkg::FRAC_BITS-1:0] phase_o
);
  import lir_pkg::*;

  state_e             state_q, state_d;
  logic               primed_q, primed_d;
  logic [PHASE_W-1:0] phase_q, phase_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [RATIO_W-1:0] ratio_q;
  in_word_t           prev_q, prev_d;
  in_word_t           cur_q, cur_d;
  logic [SUM_W-1:0]   phase_ext;
  logic [SUM_W-1:0]   next_phase;
  logic               accept;
  logic               is_last;

  assign phase_ext  = SUM_W'(phase_q);
  assign next_phase = phase_ext + SUM_W'(ratio_q);
  assign accept     = in_valid_i && (state_q == ST_IDLE);
  assign is_last    = (next_phase >= ONE_Q) || (cnt_q == CNT_LAST);

  always_comb begin
    state_d  = state_q;
    primed_d = primed_q;
    phase_d  = phase_q;
    cnt_d    = cnt_q;
    prev_d   = prev_q;
    cur_d    = cur_q;
    issue_o  = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (!primed_q) begin
            prev_d   = in_word_i;
            primed_d = 1'b1;
          end else if (phase_ext >= ONE_Q) begin
            // Downsampling: this interval holds no output point.
            phase_d = PHASE_W'(phase_ext - ONE_Q);
            prev_d  = in_word_i;
          end else begin
            cur_d   = in_word_i;
            cnt_d   = '0;
            state_d = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (advance_i) begin
          issue_o.valid = 1'b1;
          issue_o.last  = is_last;
          if (is_last) begin
            // Points beyond the per-word limit are dropped and the phase restarts.
            phase_d = (next_phase >= ONE_Q) ? PHASE_W'(next_phase - ONE_Q) : '0;
            prev_d  = cur_q;
            state_d = ST_IDLE;
          end else begin
            phase_d = PHASE_W'(next_phase);
            cnt_d   = cnt_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      primed_q <= 1'b0;
      phase_q  <= '0;
      cnt_q    <= '0;
      ratio_q  <= RATIO_RESET;
    end else begin
      state_q  <= state_d;
      primed_q <= primed_d;
      phase_q  <= phase_d;
      cnt_q    <= cnt_d;
      if (cfg_we_i) begin
        ratio_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    cur_q  <= cur_d;
  end

  assign in_stall_o = (state_q != ST_IDLE);
  assign prev_o     = prev_q;
  assign cur_o      = cur_q;
  assign phase_o    = phase_q[FRAC_BITS-1:0];

  `LIR_ASSERT_IMP(a_run_phase_frac, clk_i, rst_ni, state_q == ST_RUN, phase_ext < ONE_Q)
  `LIR_ASSERT_NXT(a_last_to_idle, clk_i, rst_ni, issue_o.valid && issue_o.last, state_q == ST_IDLE)
  `LIR_ASSERT_NXT(a_start_run, clk_i, rst_ni, accept && primed_q && (phase_ext < ONE_Q), state_q == ST_RUN)

endmodule

`default_nettype wire

// ===== hw/rtl/lir_merge.sv =====
`default_nettype none

module lir_merge (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  lir_pkg::issue_t                     issue_i,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] left_i,
  input  logic signed [lir_pkg::SAMPLE_W-1:0] right_i,
  output logic                                advance_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output lir_pkg::out_word_t                  out_word_o
);
  import lir_pkg::*;

  logic      mul_valid_q;
  logic      mul_last_q;
  logic      out_valid_q;
  out_word_t out_q;

  // The whole pipeline moves together, and only when the output register can take a word.
  assign advance_o = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance_o) begin
      mul_valid_q <= issue_i.valid;
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o) begin
      mul_last_q        <= issue_i.last;
      out_q.out_left    <= left_i;
      out_q.out_right   <= right_i;
      out_q.last_of_run <= mul_last_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

`default_nettype wire

// ===== hw/rtl/linear_interp_resampler.sv =====
// Channel  Direction  Handshake            Word
// in       input      in_valid_i/stall_o   in_word_t: sample_left, sample_right
// out      output     out_valid_o/stall_i  out_word_t: out_left, out_right, last_of_run
// cfg      input      cfg_we_i             rate_ratio, 21 bits
//
// A word is taken in idle and then gives one output a cycle while the output is not
// stalled; in_stall_o holds the input off until its last output (n at most MAX_UPSAMPLE).
// After their issue, outputs pass through the multiplier register, then the output register.
// Reset clears the phase and the primed flag and sets rate_ratio to 1.0.
// A stall on a valid output word freezes the sequencer's run and both pipeline registers together.
`default_nettype none

module linear_interp_resampler (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  lir_pkg::in_word_t           in_word_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output lir_pkg::out_word_t          out_word_o,
  input  logic                        cfg_we_i,
  input  logic [lir_pkg::RATIO_W-1:0] cfg_wdata_i
);
  import lir_pkg::*;

  issue_t                     issue;
  in_word_t                   prev_w;
  in_word_t                   cur_w;
  logic [FRAC_BITS-1:0]       phase;
  logic                       advance;
  logic signed [SAMPLE_W-1:0] res_left;
  logic signed [SAMPLE_W-1:0] res_right;

  lir_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .advance_i   (advance),
    .issue_o     (issue),
    .prev_o      (prev_w),
    .cur_o       (cur_w),
    .phase_o     (phase)
  );

  lir_lane u_lane_left (
    .clk_i     (clk_i),
    .advance_i (advance),
    .prev_i    (prev_w.sample_left),
    .cur_i     (cur_w.sample_left),
    .phase_i   (phase),
    .res_o     (res_left)
  );

  lir_lane u_lane_right (
    .clk_i     (clk_i),
    .advance_i (advance),
    .prev_i    (prev_w.sample_right),
    .cur_i     (cur_w.sample_right),
    .phase_i   (phase),
    .res_o     (res_right)
  );

  lir_merge u_merge (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .issue_i     (issue),
    .left_i      (res_left),
    .right_i     (res_right),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire

// ===== dv/tb_linear_interp_resampler.sv =====
`default_nettype none

module tb_linear_interp_resampler;
  timeunit 1ns;
  timeprecision 1ps;

  import lir_pkg::*;

  localparam longint ONE_PH         = longint'(1) << FRAC_BITS;
  localparam longint HALF_PH        = longint'(1) << (FRAC_BITS - 1);
  localparam int     SETTLE_CYCLES  = 40;
  localparam int     HOLD_CYCLES    = 400;
  localparam int     WATCHDOG_LIMIT = 5000;
  localparam int     SEGMENTS       = 12;
  localparam int     SEG_FRAMES     = 38;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 in_valid_i  = 1'b0;
  logic                 in_stall_o;
  in_word_t             in_word_i   = '0;
  logic                 out_valid_o;
  logic                 out_stall_i = 1'b0;
  out_word_t            out_word_o;
  logic                 cfg_we_i    = 1'b0;
  logic [RATIO_W-1:0]   cfg_wdata_i = '0;

  wire in_fire  = in_valid_i && !in_stall_o;
  wire out_fire = out_valid_o && !out_stall_i;

  // Shadow of the resampler state, advanced once per accepted frame.
  longint               ratio_q      = 65536;
  longint               phase_q      = 0;
  logic signed [15:0]   prev_left_q  = '0;
  logic signed [15:0]   prev_right_q = '0;
  logic                 primed_q     = 1'b0;

  in_word_t             frames_to_send[$];
  out_word_t            expected_points[$];
  out_word_t            want;
  int                   mismatches    = 0;
  int                   send_idle_pct = 13;
  int                   recv_idle_pct = 73;
  int                   hold_req      = 0;
  int                   hold_ack      = 0;
  int                   hold_left     = 0;
  int                   quiet_cycles  = 0;
  int                   seg;
  int                   k;

  linear_interp_resampler uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Floor of the biased sum gives round to nearest with ties going upwards.
  function automatic logic signed [15:0] blend(input logic signed [15:0] a,
                                               input logic signed [15:0] b,
                                               input longint ph);
    longint acc;
    acc = (ONE_PH - ph) * longint'(a) + ph * longint'(b) + HALF_PH;
    return 16'(acc >>> FRAC_BITS);
  endfunction

  task automatic resample_frame(input in_word_t w);
    int        n;
    out_word_t pt;
    n = 0;
    if (!primed_q) begin
      prev_left_q  = w.sample_left;
      prev_right_q = w.sample_right;
      primed_q     = 1'b1;
      return;
    end
    while (phase_q < ONE_PH && n < MAX_UPSAMPLE) begin
      pt.out_left  = blend(prev_left_q, w.sample_left, phase_q);
      pt.out_right = blend(prev_right_q, w.sample_right, phase_q);
      n++;
      phase_q += ratio_q;
      pt.last_of_run = !(phase_q < ONE_PH && n < MAX_UPSAMPLE);
      expected_points.push_back(pt);
    end
    // A run cut short by the output cap restarts the phase at zero.
    if (phase_q < ONE_PH) phase_q = 0;
    else phase_q -= ONE_PH;
    prev_left_q  = w.sample_left;
    prev_right_q = w.sample_right;
  endtask

  task automatic push_frame(input logic signed [15:0] l, input logic signed [15:0] r);
    in_word_t w;
    w.sample_left  = l;
    w.sample_right = r;
    frames_to_send.push_back(w);
  endtask

  function automatic logic signed [15:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'sh0000;
      3: return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [RATIO_W-1:0] rand_ratio();
    case ($urandom_range(0, 5))
      0: return RATIO_W'($urandom_range(4096, 65536));
      1: return RATIO_W'($urandom_range(65536, 1048576));
      2: return RATIO_W'($urandom);
      3: return RATIO_W'($urandom_range(0, 4095));
      4: return RATIO_W'($urandom_range(4096, 20000));
      default: return ($urandom_range(0, 1) != 0) ? RATIO_W'(4096) : RATIO_W'(1048576);
    endcase
  endfunction

  // Frames that give no point may still be in flight, hence the extra cycles.
  task automatic settle();
    while (frames_to_send.size() != 0 || in_valid_i || expected_points.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ratio(input logic [RATIO_W-1:0] v);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    ratio_q      = longint'(v);
    @(negedge clk_i);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_word_i  <= '0;
    end else if (in_fire || !in_valid_i) begin
      if (in_fire) resample_frame(in_word_i);
      if (frames_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid_i <= 1'b1;
        in_word_i  <= frames_to_send.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_fire) begin
        if (expected_points.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected word, expected none, got %0d %0d %0b", $time,
                   out_word_o.out_left, out_word_o.out_right, out_word_o.last_of_run);
        end else begin
          want = expected_points.pop_front();
          if (out_word_o.out_left !== want.out_left) begin
            mismatches++;
            $display("%0t: out_left expected %0d, got %0d", $time,
                     want.out_left, out_word_o.out_left);
          end
          if (out_word_o.out_right !== want.out_right) begin
            mismatches++;
            $display("%0t: out_right expected %0d, got %0d", $time,
                     want.out_right, out_word_o.out_right);
          end
          if (out_word_o.last_of_run !== want.last_of_run) begin
            mismatches++;
            $display("%0t: last_of_run expected %0b, got %0b", $time,
                     want.last_of_run, out_word_o.last_of_run);
          end
        end
      end
      // A long hold-off lets the block fill up and push back on its input.
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (hold_ack != hold_req) begin
        hold_ack    = hold_req;
        hold_left   = HOLD_CYCLES;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= ($urandom_range(0, 99) < recv_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || in_fire || out_fire || cfg_we_i) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // The first frame only primes the block; the rest run at the reset ratio.
    push_frame(16'sh0000, 16'sh0000);
    push_frame(16'sh7fff, 16'sh8000);
    push_frame(16'sh8000, 16'sh7fff);
    push_frame(16'sh7fff, 16'sh7fff);
    push_frame(16'sh8000, 16'sh8000);
    push_frame(-16'sd1, 16'sd1);
    push_frame(16'sh0000, 16'sh0000);

    // Sixteen points per frame exactly, with rounding ties between 0 and 1.
    write_ratio(RATIO_W'(4096));
    push_frame(16'sd1, -16'sd1);
    push_frame(16'sd0, 16'sd0);
    push_frame(16'sh7fff, 16'sh8000);
    push_frame(16'sh8000, 16'sh7fff);

    // Below the cap: the tail of each interval is dropped.
    write_ratio(RATIO_W'(4095));
    push_frame(16'sd100, -16'sd100);
    push_frame(16'sh8000, 16'sh7fff);

    write_ratio(RATIO_W'(0));
    push_frame(16'sd5, 16'sd7);
    push_frame(-16'sd5, -16'sd7);

    // Downsampling: most frames give no point at all.
    write_ratio(RATIO_W'(1048576));
    push_frame(16'sd1, 16'sd2);
    push_frame(16'sd3, 16'sd4);
    push_frame(16'sd5, 16'sd6);
    push_frame(16'sd7, 16'sd8);

    write_ratio({RATIO_W{1'b1}});
    push_frame(16'sh7fff, 16'sh8000);
    push_frame(-16'sd1, -16'sd1);
    push_frame(16'sd0, 16'sd0);

    for (seg = 0; seg < SEGMENTS; seg++) begin
      write_ratio(rand_ratio());
      if (seg == 4) begin
        send_idle_pct = 73;
        recv_idle_pct = 13;
      end else if (seg == 8) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (k = 0; k < SEG_FRAMES; k++)
        push_frame(rand_sample(), rand_sample());
      if (seg == 9) hold_req++;
    end

    settle();
    if (expected_points.size() != 0) mismatches++;
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/lir_pkg.sv
hw/rtl/lir_lane.sv
hw/rtl/lir_ctrl.sv
hw/rtl/lir_merge.sv
hw/rtl/linear_interp_resampler.sv
dv/tb_linear_interp_resampler.sv
